>>> rtl/assert_macros.svh
// Assertion macros shared by the circular deque RTL.
// Defined empty when NO_ASSERTIONS is set; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cdq assertion failed");
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cdq assertion failed");
`else
`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/cdq_pkg.sv
// Package for the circular deque: field widths, operation and status codes,
// controller state type and ring request struct. No dependencies.
`default_nettype none
package cdq_pkg;
	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int CFG_W         = 5;
	localparam int OP_W          = 3;
	localparam int STATUS_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} state_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} ring_req_t;
endpackage
`default_nettype wire

>>> rtl/cdq_ring.sv
// Ring store of the circular deque: one write port, one read port with
// registered read data. Uses cdq_pkg for the request struct.
`default_nettype none
module cdq_ring #(
	parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire cdq_pkg::ring_req_t       req,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WORD_BITS-1:0]     wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WORD_BITS-1:0]     rd_data
);
	import cdq_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/cdq_ctrl.sv
// Deque controller: head/tail/count registers, operation decode, dump
// sequencer, read-data stage and result register. Uses cdq_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cdq_ctrl #(
	parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF,
	parameter int CNT_W     = $clog2(DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cdq_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [cdq_pkg::OP_W-1:0]     item_op,
	input  wire logic [WORD_BITS-1:0]         item_value,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic [cdq_pkg::STATUS_W-1:0]      res_status,
	output logic [WORD_BITS-1:0]              res_data,
	output logic [CNT_W-1:0]                  res_occ,
	output logic                              res_last,
	output cdq_pkg::ring_req_t                ring_req,
	output logic [$clog2(DEPTH)-1:0]          ring_wr_addr,
	output logic [WORD_BITS-1:0]              ring_wr_data,
	output logic [$clog2(DEPTH)-1:0]          ring_rd_addr,
	input  wire logic [WORD_BITS-1:0]         ring_rd_data
);
	import cdq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
	logic [CNT_W-1:0]   count_q, count_d, remain_q, remain_d, cap_q, cap_d;
	logic               pend_s1, pend_d, last_s1, last_d;
	logic               res_valid_q, res_last_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic [CNT_W-1:0]   res_occ_q;
	logic               load;
	status_t            ld_status;
	logic [WORD_BITS-1:0] ld_data;
	logic [CNT_W-1:0]   ld_occ;
	logic               ld_last;
	logic               out_free, acc, cfg_acc;

	function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nx;
		nx = CNT_W'(i) + CNT_W'(1);
		return (nx >= cap) ? '0 : nx[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] pv;
		pv = cap - CNT_W'(1);
		return (i == '0) ? pv[IDX_W-1:0] : i - IDX_W'(1);
	endfunction

	assign out_free   = !res_valid_q || res_ready;
	assign item_ready = (state_q == S_IDLE) && !pend_s1 && out_free;
	assign acc        = item_valid && item_ready;
	assign cfg_ready  = (state_q == S_IDLE) && !pend_s1 && !res_valid_q && !item_valid;
	assign cfg_acc    = cfg_valid && cfg_ready;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		ptr_d        = ptr_q;
		count_d      = count_q;
		remain_d     = remain_q;
		cap_d        = cap_q;
		pend_d       = pend_s1;
		last_d       = last_s1;
		ring_req     = '0;
		ring_wr_addr = head_q;
		ring_wr_data = item_value;
		ring_rd_addr = ptr_q;
		load         = 1'b0;
		ld_status    = ST_DONE;
		ld_data      = '0;
		ld_occ       = count_q;
		ld_last      = 1'b1;

		if (pend_s1 && out_free) begin
			load    = 1'b1;
			ld_data = ring_rd_data;
			ld_last = last_s1;
			pend_d  = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (item_op)
						OP_PUSH_FRONT, OP_PUSH_REAR: begin
							load = 1'b1;
							if (count_q == cap_q) begin
								ld_status = ST_FULL;
							end else begin
								ring_req.wr = 1'b1;
								if (count_q == '0) begin
									head_d = '0;
									tail_d = '0;
								end else if (item_op == OP_PUSH_FRONT) begin
									head_d = step_down(head_q, cap_q);
								end else begin
									tail_d = step_up(tail_q, cap_q);
								end
								ring_wr_addr = (item_op == OP_PUSH_FRONT) ? head_d : tail_d;
								count_d = count_q + CNT_W'(1);
								ld_occ  = count_d;
							end
						end
						OP_POP_FRONT, OP_POP_REAR: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								ring_req.rd  = 1'b1;
								ring_rd_addr = (item_op == OP_POP_FRONT) ? head_q : tail_q;
								pend_d       = 1'b1;
								last_d       = 1'b1;
								count_d      = count_q - CNT_W'(1);
								if (count_q == CNT_W'(1)) begin
									head_d = '0;
									tail_d = '0;
								end else if (item_op == OP_POP_FRONT) begin
									head_d = step_up(head_q, cap_q);
								end else begin
									tail_d = step_down(tail_q, cap_q);
								end
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								ring_req.rd  = 1'b1;
								ring_rd_addr = head_q;
								pend_d       = 1'b1;
								last_d       = (count_q == CNT_W'(1));
								ptr_d        = step_up(head_q, cap_q);
								remain_d     = count_q - CNT_W'(1);
								if (count_q != CNT_W'(1)) begin
									state_d = S_DUMP;
								end
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_DUMP: begin
				if (!pend_s1 || out_free) begin
					ring_req.rd  = 1'b1;
					ring_rd_addr = ptr_q;
					pend_d       = 1'b1;
					last_d       = (remain_q == CNT_W'(1));
					ptr_d        = step_up(ptr_q, cap_q);
					remain_d     = remain_q - CNT_W'(1);
					if (remain_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_acc) begin
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
			if (cfg_data == '0) begin
				cap_d = CNT_W'(1);
			end else if (32'(cfg_data) > DEPTH) begin
				cap_d = CNT_W'(DEPTH);
			end else begin
				cap_d = CNT_W'(cfg_data);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			ptr_q       <= '0;
			count_q     <= '0;
			remain_q    <= '0;
			cap_q       <= CNT_W'(DEPTH);
			pend_s1     <= 1'b0;
			last_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			ptr_q    <= ptr_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			cap_q    <= cap_d;
			pend_s1  <= pend_d;
			last_s1  <= last_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_status_q <= ld_status;
			res_data_q   <= ld_data;
			res_occ_q    <= ld_occ;
			res_last_q   <= ld_last;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_status = res_status_q;
	assign res_data   = res_data_q;
	assign res_occ    = res_occ_q;
	assign res_last   = res_last_q;

	`CDQ_ASSERT_IMPL(a_count_le_cap, clk, arst_n, 1'b1, count_q <= cap_q)
	`CDQ_ASSERT_IMPL(a_empty_ptrs_zero, clk, arst_n, count_q == '0, head_q == '0 && tail_q == '0)
	`CDQ_ASSERT_IMPL(a_ptrs_in_range, clk, arst_n, 1'b1, CNT_W'(head_q) < cap_q && CNT_W'(tail_q) < cap_q)
	`CDQ_ASSERT_NEXT(a_dump_holds_input, clk, arst_n, state_q == S_DUMP, !acc)
endmodule
`default_nettype wire

>>> rtl/circular_deque_top.sv
// Top level of the circular deque: stream ports, controller and ring store.
// Depends on cdq_pkg, cdq_ctrl and cdq_ring.
// A push, a refused operation or an unknown code is loaded into the result register
// when it is taken; a pop's word comes from the ring memory, whose read data is
// registered, and then goes to the result register. A dump reads the memory's single
// read port once per word, and the next item is taken after the last word is loaded
// into the result register. Writing capacity_in_use empties the deque; values of 0
// act as 1 and values above DEPTH act as DEPTH. A write is taken only while no beat
// is offered, no dump runs and no result waits.
`default_nettype none
module circular_deque_top #(
	parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF,
	parameter int CNT_W     = $clog2(DEPTH + 1),
	parameter int IN_TD_W   = ((WORD_BITS + 7) / 8) * 8,
	parameter int OUT_TD_W  = ((WORD_BITS + CNT_W + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cdq_pkg::CFG_W-1:0]       cfg_data,     // capacity_in_use
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [IN_TD_W-1:0]              s_tdata,      // value
	input  wire logic [cdq_pkg::OP_W-1:0]        s_tuser,      // operation
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [OUT_TD_W-1:0]                  m_tdata,      // data, occupancy
	output logic [cdq_pkg::STATUS_W-1:0]         m_tuser,      // status
	output logic                                 m_tlast
);
	import cdq_pkg::*;

	ring_req_t                ring_req;
	logic [$clog2(DEPTH)-1:0] ring_wr_addr, ring_rd_addr;
	logic [WORD_BITS-1:0]     ring_wr_data, ring_rd_data;
	logic [WORD_BITS-1:0]     res_data;
	logic [CNT_W-1:0]         res_occ;

	cdq_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (s_tvalid),
		.item_ready   (s_tready),
		.item_op      (s_tuser),
		.item_value   (s_tdata[WORD_BITS-1:0]),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_status   (m_tuser),
		.res_data     (res_data),
		.res_occ      (res_occ),
		.res_last     (m_tlast),
		.ring_req     (ring_req),
		.ring_wr_addr (ring_wr_addr),
		.ring_wr_data (ring_wr_data),
		.ring_rd_addr (ring_rd_addr),
		.ring_rd_data (ring_rd_data)
	);

	cdq_ring #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ring (
		.clk     (clk),
		.req     (ring_req),
		.wr_addr (ring_wr_addr),
		.wr_data (ring_wr_data),
		.rd_addr (ring_rd_addr),
		.rd_data (ring_rd_data)
	);

	assign m_tdata = OUT_TD_W'({res_occ, res_data});
endmodule
`default_nettype wire

>>> tb/sv/circular_deque_top_tb.sv
// Self-checking testbench for circular_deque_top: directed and random operation
// streams are checked against a cycle-free shadow deque, beat by beat.
// Depends on cdq_pkg and the circular_deque_top RTL.
`default_nettype none
module circular_deque_top_tb;
	import cdq_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int WORD_BITS     = WORD_BITS_DEF;
	localparam int CNT_W         = $clog2(DEPTH + 1);
	localparam int IN_TD_W       = ((WORD_BITS + 7) / 8) * 8;
	localparam int OUT_TD_W      = ((WORD_BITS + CNT_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 300;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		status_t              status;
		logic [WORD_BITS-1:0] data;
		logic [CNT_W-1:0]     occupancy;
		logic                 last;
	} deque_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TD_W-1:0]    s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_TD_W-1:0]   m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  m_tlast;

	logic [WORD_BITS-1:0]  shadow_ring [DEPTH];
	int unsigned           shadow_head;
	int unsigned           shadow_tail;
	logic                  shadow_empty;
	logic [CFG_W-1:0]      shadow_capacity;

	deque_result_t         pending_results [$];
	int unsigned           error_count = 0;
	int unsigned           cycle_count = 0;
	logic                  quiet;
	logic                  hold_request;
	logic                  hold_done;

	circular_deque_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("circular_deque_top_tb: errors");
			$finish;
		end
	end

	function automatic int unsigned capacity_now();
		if (shadow_capacity == 0)
			return 1;
		if (shadow_capacity > DEPTH)
			return DEPTH;
		return 32'(shadow_capacity);
	endfunction

	function automatic int unsigned ring_next(input int unsigned i, input int unsigned cap);
		return (i + 1 >= cap) ? 0 : i + 1;
	endfunction

	function automatic int unsigned ring_prev(input int unsigned i, input int unsigned cap);
		return (i == 0 || i >= cap) ? cap - 1 : i - 1;
	endfunction

	function automatic int unsigned words_held();
		int unsigned cap;
		cap = capacity_now();
		if (shadow_empty)
			return 0;
		if (shadow_tail >= shadow_head)
			return shadow_tail - shadow_head + 1;
		return shadow_tail + cap - shadow_head + 1;
	endfunction

	task automatic queue_result(input status_t status, input logic [WORD_BITS-1:0] data,
		input logic last);
		deque_result_t r;
		r.status    = status;
		r.data      = data;
		r.occupancy = CNT_W'(words_held());
		r.last      = last;
		pending_results.push_back(r);
	endtask

	task automatic predict_deque(input logic [OP_W-1:0] op, input logic [WORD_BITS-1:0] value);
		int unsigned          cap;
		int unsigned          n;
		int unsigned          idx;
		logic                 full;
		logic [WORD_BITS-1:0] word;
		cap  = capacity_now();
		full = !shadow_empty && ring_next(shadow_tail, cap) == shadow_head;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full) begin
					queue_result(ST_FULL, '0, 1'b1);
				end else begin
					if (shadow_empty) begin
						shadow_head    = 0;
						shadow_tail    = 0;
						shadow_empty   = 1'b0;
						shadow_ring[0] = value;
					end else if (op == OP_PUSH_FRONT) begin
						shadow_head = ring_prev(shadow_head, cap);
						shadow_ring[shadow_head % DEPTH] = value;
					end else begin
						shadow_tail = ring_next(shadow_tail, cap);
						shadow_ring[shadow_tail % DEPTH] = value;
					end
					queue_result(ST_DONE, '0, 1'b1);
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (shadow_empty) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					word = (op == OP_POP_FRONT) ? shadow_ring[shadow_head % DEPTH]
						: shadow_ring[shadow_tail % DEPTH];
					if (shadow_head == shadow_tail) begin
						shadow_head  = 0;
						shadow_tail  = 0;
						shadow_empty = 1'b1;
					end else if (op == OP_POP_FRONT) begin
						shadow_head = ring_next(shadow_head, cap);
					end else begin
						shadow_tail = ring_prev(shadow_tail, cap);
					end
					queue_result(ST_DONE, word, 1'b1);
				end
			end
			OP_DUMP: begin
				n   = words_held();
				idx = shadow_head;
				if (n == 0)
					queue_result(ST_EMPTY, '0, 1'b1);
				for (int unsigned k = 0; k < n; k++) begin
					queue_result(ST_DONE, shadow_ring[idx % DEPTH], k + 1 == n);
					idx = ring_next(idx, cap);
				end
			end
			default: begin
				queue_result(ST_DONE, '0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk) begin : check_results
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected beat, expected none, got tuser %0d tdata %h tlast %b",
					$time, m_tuser, m_tdata, m_tlast);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					error_count++;
					$display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
				end
				if (m_tdata[WORD_BITS-1:0] !== want.data) begin
					error_count++;
					$display("%0t: data expected %h got %h", $time, want.data,
						m_tdata[WORD_BITS-1:0]);
				end
				if (m_tdata[WORD_BITS +: CNT_W] !== want.occupancy) begin
					error_count++;
					$display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
						m_tdata[WORD_BITS +: CNT_W]);
				end
				if (m_tlast !== want.last) begin
					error_count++;
					$display("%0t: last expected %b got %b", $time, want.last, m_tlast);
				end
			end
		end
	end

	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_BITS-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TD_W'(value);
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predict_deque(op, value);
	endtask

	task automatic release_stream();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		release_stream();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] cap_value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap_value;
		do @(posedge clk); while (!cfg_ready);
		shadow_capacity = cap_value;
		shadow_head     = 0;
		shadow_tail     = 0;
		shadow_empty    = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_refusals();
		send_item(OP_POP_FRONT, $urandom());
		send_item(OP_POP_REAR, $urandom());
		send_item(OP_DUMP, $urandom());
		send_item(OP_SPARE_LO, $urandom());
		send_item(OP_SPARE_HI, $urandom());
		wait_drained();
	endtask

	task automatic test_value_extremes();
		send_item(OP_PUSH_REAR, 32'h7fff_ffff);
		send_item(OP_PUSH_FRONT, 32'h8000_0000);
		send_item(OP_PUSH_REAR, 32'h0000_0000);
		send_item(OP_PUSH_FRONT, 32'hffff_ffff);
		send_item(OP_DUMP, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_REAR, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_REAR, '0);
		send_item(OP_POP_REAR, '0);
		wait_drained();
	endtask

	task automatic test_capacity_edges();
		write_capacity(5'd1);
		send_item(OP_PUSH_FRONT, $urandom());
		send_item(OP_PUSH_REAR, $urandom());
		send_item(OP_DUMP, '0);
		send_item(OP_POP_REAR, '0);
		write_capacity(5'd0);
		send_item(OP_PUSH_REAR, $urandom());
		send_item(OP_PUSH_FRONT, $urandom());
		write_capacity(5'd2);
		send_item(OP_DUMP, '0);
		send_item(OP_PUSH_REAR, $urandom());
		send_item(OP_PUSH_FRONT, $urandom());
		send_item(OP_PUSH_REAR, $urandom());
		send_item(OP_DUMP, '0);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int unsigned items, input logic [CFG_W-1:0] cap_value);
		logic             draining;
		logic [OP_W-1:0]  op;
		int unsigned      pick;
		int unsigned      cap;
		write_capacity(cap_value);
		cap      = capacity_now();
		draining = 1'b0;
		repeat (items) begin
			if (words_held() == 0)
				draining = 1'b0;
			else if (words_held() >= cap)
				draining = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			else if (pick < 15)
				op = OP_DUMP;
			else if (pick < (draining ? 30 : 85))
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
			else
				op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
			send_item(op, $urandom());
			maybe_idle();
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_capacity(5'd16);
		hold_request = 1'b1;
		repeat (DEPTH)
			send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom());
		repeat (4) begin
			send_item(OP_DUMP, '0);
			send_item(OP_PUSH_REAR, $urandom());
		end
		repeat (6)
			send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, '0);
		send_item(OP_DUMP, '0);
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		shadow_head     = 0;
		shadow_tail     = 0;
		shadow_empty    = 1'b1;
		shadow_capacity = 5'd16;
		foreach (shadow_ring[i])
			shadow_ring[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_refusals();
		test_value_extremes();
		test_capacity_edges();
		test_random_traffic(30, 5'd16);
		test_random_traffic(30, 5'd1);
		test_random_traffic(30, 5'd2);
		test_random_traffic(50, CFG_W'($urandom_range(3, 15)));
		test_random_traffic(25, 5'd0);
		test_random_traffic(40, 5'd31);
		test_random_traffic(30, 5'd21);
		test_random_traffic(30, 5'd10);
		test_backpressure();
		quiet = 1'b1;
		test_random_traffic(35, 5'd16);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("circular_deque_top_tb: clean");
		else
			$display("circular_deque_top_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
